[src/tqct_pkg.sv]
// ----------------------------------------------------------------------------
// tqct_pkg
// Shared constants and types for the time-over-threshold crossing-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package tqct_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int FRAC_W      = 8;
  localparam int TIME_W      = 40;
  localparam int VAL_W       = 16;
  localparam int TS_W        = 32;
  localparam int THR_W       = 17;
  localparam int YMT_W       = 18;              // y1 - threshold
  localparam int DT_W        = TS_W + 1;        // signed time difference
  localparam int PROD_W      = YMT_W + DT_W;    // product before the fraction shift
  localparam int DIV_W       = PROD_W + FRAC_W; // dividend and quotient width
  localparam int CNT_W       = $clog2(DIV_W);
  localparam int SUM_W       = DIV_W + 2;       // signed crossing-time sum
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(MAX_SAMPLES - 1);
  localparam logic [TIME_W-1:0] FAIL_TIME = TIME_W'(10 * (1 << FRAC_W));
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

  // One finished waveform, handed from the scanner to the interpolator
  typedef struct packed {
    logic                    fail;
    logic signed [YMT_W-1:0] ymt;
    logic signed [DT_W-1:0]  dt;
    logic [VAL_W-1:0]        den;
    logic [TS_W-1:0]         cand_time;
  } job_t;

endpackage

`default_nettype wire

[src/tqct_queue.sv]
// ----------------------------------------------------------------------------
// tqct_queue
// Short first-word-fall-through queue of finished waveforms.
// ----------------------------------------------------------------------------
`default_nettype none

module tqct_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tqct_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output tqct_pkg::job_t     pop_job
);

  tqct_pkg::job_t                  slots [tqct_pkg::QDEPTH];
  logic [tqct_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tqct_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tqct_pkg::QCNT_W-1:0]     count;

  assign full    = (count == tqct_pkg::QCNT_W'(tqct_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[src/tqct_front.sv]
// ----------------------------------------------------------------------------
// tqct_front
// Sample scanner: finds and qualifies the candidate, emits one job per trace.
// ----------------------------------------------------------------------------
`default_nettype none

module tqct_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [tqct_pkg::VAL_W-1:0]   sample_value,
  input  wire logic [tqct_pkg::TS_W-1:0]           sample_time,
  input  wire logic                                end_of_trace,
  input  wire logic signed [tqct_pkg::THR_W-1:0]   threshold,
  input  wire logic signed [tqct_pkg::VAL_W-1:0]   baseline_offset,
  input  wire logic [tqct_pkg::TS_W-1:0]           tot_window,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output tqct_pkg::job_t                           q_job
);

  logic                                checking_mode;
  logic                                scan_stopped;
  logic [tqct_pkg::IDX_W-1:0]          sample_index;
  logic signed [tqct_pkg::VAL_W-1:0]   previous_value;
  logic [tqct_pkg::TS_W-1:0]           previous_time;
  logic [tqct_pkg::IDX_W-1:0]          candidate_index;
  logic signed [tqct_pkg::VAL_W-1:0]   candidate_value;
  logic [tqct_pkg::TS_W-1:0]           candidate_time;
  logic signed [tqct_pkg::VAL_W-1:0]   before_value;
  logic [tqct_pkg::TS_W-1:0]           before_time;

  logic                                checking_mode_next;
  logic                                scan_stopped_next;
  logic [tqct_pkg::IDX_W-1:0]          candidate_index_next;
  logic signed [tqct_pkg::VAL_W-1:0]   candidate_value_next;
  logic [tqct_pkg::TS_W-1:0]           candidate_time_next;
  logic signed [tqct_pkg::VAL_W-1:0]   before_value_next;
  logic [tqct_pkg::TS_W-1:0]           before_time_next;

  logic signed [tqct_pkg::YMT_W-1:0]   corrected;
  logic                                above;
  logic [tqct_pkg::TS_W:0]             limit;
  logic                                late;
  logic signed [tqct_pkg::VAL_W:0]     den_full;
  logic                                accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;

  assign corrected = tqct_pkg::YMT_W'(sample_value) - tqct_pkg::YMT_W'(baseline_offset);
  assign above     = corrected > tqct_pkg::YMT_W'(threshold);

  always_comb begin
    checking_mode_next   = checking_mode;
    scan_stopped_next    = scan_stopped;
    candidate_index_next = candidate_index;
    candidate_value_next = candidate_value;
    candidate_time_next  = candidate_time;
    before_value_next    = before_value;
    before_time_next     = before_time;
    limit                = '0;
    late                 = 1'b0;
    if (!scan_stopped) begin
      if (!checking_mode && above) begin
        candidate_index_next = sample_index;
        candidate_value_next = sample_value;
        candidate_time_next  = sample_time;
        before_value_next    = previous_value;
        before_time_next     = previous_time;
        checking_mode_next   = 1'b1;
      end
      if (checking_mode_next) begin
        limit = {1'b0, candidate_time_next} + {1'b0, tot_window};
        late  = {1'b0, sample_time} > limit;
        if (!above || late) begin
          checking_mode_next = 1'b0;
          if (late) begin
            scan_stopped_next = 1'b1;
          end
        end
      end
    end
  end

  // Job for the interpolator, built from the state this item leaves behind
  assign den_full = (tqct_pkg::VAL_W+1)'(candidate_value_next)
                  - (tqct_pkg::VAL_W+1)'(before_value_next);

  always_comb begin
    q_job.fail      = (candidate_index_next == '0) || (candidate_index_next == sample_index)
                   || den_full[tqct_pkg::VAL_W] || (den_full == '0);
    q_job.ymt       = tqct_pkg::YMT_W'(candidate_value_next)
                    - tqct_pkg::YMT_W'(baseline_offset)
                    - tqct_pkg::YMT_W'(threshold);
    q_job.dt        = {1'b0, candidate_time_next} - {1'b0, before_time_next};
    q_job.den       = den_full[tqct_pkg::VAL_W-1:0];
    q_job.cand_time = candidate_time_next;
  end

  assign q_push = accept && end_of_trace;

  always_ff @(posedge clk) begin
    if (rst) begin
      checking_mode   <= 1'b0;
      scan_stopped    <= 1'b0;
      sample_index    <= '0;
      previous_value  <= '0;
      previous_time   <= '0;
      candidate_index <= '0;
      candidate_value <= '0;
      candidate_time  <= '0;
      before_value    <= '0;
      before_time     <= '0;
    end else if (accept) begin
      if (end_of_trace) begin
        checking_mode   <= 1'b0;
        scan_stopped    <= 1'b0;
        sample_index    <= '0;
        previous_value  <= '0;
        previous_time   <= '0;
        candidate_index <= '0;
        candidate_value <= '0;
        candidate_time  <= '0;
        before_value    <= '0;
        before_time     <= '0;
      end else begin
        checking_mode   <= checking_mode_next;
        scan_stopped    <= scan_stopped_next;
        previous_value  <= sample_value;
        previous_time   <= sample_time;
        candidate_index <= candidate_index_next;
        candidate_value <= candidate_value_next;
        candidate_time  <= candidate_time_next;
        before_value    <= before_value_next;
        before_time     <= before_time_next;
        if (sample_index != tqct_pkg::IDX_LAST) begin
          sample_index <= sample_index + 1'b1;
        end
      end
    end
  end

  a_stop_ends_check: assert property (@(posedge clk) disable iff (rst)
      scan_stopped |-> !checking_mode)
    else $error("checking while scan stopped");
  a_check_has_cand: assert property (@(posedge clk) disable iff (rst)
      checking_mode |-> candidate_index <= sample_index)
    else $error("candidate lies ahead of scan");

endmodule

`default_nettype wire

[src/tqct_back.sv]
// ----------------------------------------------------------------------------
// tqct_back
// Interpolator: multiply, bit-serial rounded divide, saturate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tqct_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire tqct_pkg::job_t                q_job,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tqct_pkg::TIME_W-1:0]        crossing_time,
  output logic                               crossing_status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                              state;
  tqct_pkg::job_t                      job;
  logic signed [tqct_pkg::PROD_W-1:0]  prod;
  logic                                neg;
  logic [tqct_pkg::DIV_W-1:0]          quo;
  logic [tqct_pkg::VAL_W-1:0]          rem;
  logic [tqct_pkg::CNT_W-1:0]          cnt;

  logic [tqct_pkg::PROD_W-1:0]         mag;
  logic [tqct_pkg::DIV_W-1:0]          dividend;
  logic [tqct_pkg::VAL_W:0]            rem_sh;
  logic                                qbit;
  logic signed [tqct_pkg::SUM_W-1:0]   base_t;
  logic signed [tqct_pkg::SUM_W-1:0]   quo_x;
  logic signed [tqct_pkg::SUM_W-1:0]   t_sum;
  logic [tqct_pkg::TIME_W-1:0]         t_sat;
  logic                                out_free;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  // Magnitude of the numerator plus half the divisor: rounds half away from zero
  assign mag      = prod[tqct_pkg::PROD_W-1] ? tqct_pkg::PROD_W'(-prod)
                                             : tqct_pkg::PROD_W'(prod);
  assign dividend = {mag, {tqct_pkg::FRAC_W{1'b0}}}
                  + tqct_pkg::DIV_W'(job.den[tqct_pkg::VAL_W-1:1]);

  // One quotient bit per cycle, restoring form
  assign rem_sh = {rem, quo[tqct_pkg::DIV_W-1]};
  assign qbit   = rem_sh >= {1'b0, job.den};

  assign base_t = tqct_pkg::SUM_W'({job.cand_time, {tqct_pkg::FRAC_W{1'b0}}});
  assign quo_x  = tqct_pkg::SUM_W'(quo);
  assign t_sum  = neg ? (base_t + quo_x) : (base_t - quo_x);

  always_comb begin
    if (t_sum[tqct_pkg::SUM_W-1]) begin
      t_sat = '0;
    end else if (|t_sum[tqct_pkg::SUM_W-2:tqct_pkg::TIME_W]) begin
      t_sat = tqct_pkg::TIME_MAX;
    end else begin
      t_sat = t_sum[tqct_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job   <= q_job;
            state <= q_job.fail ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= $signed(job.ymt) * $signed(job.dt);
          state <= ST_PREP;
        end
        ST_PREP: begin
          neg   <= prod[tqct_pkg::PROD_W-1];
          quo   <= dividend;
          rem   <= '0;
          cnt   <= tqct_pkg::CNT_W'(tqct_pkg::DIV_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= qbit ? tqct_pkg::VAL_W'(rem_sh - {1'b0, job.den})
                      : rem_sh[tqct_pkg::VAL_W-1:0];
          quo <= {quo[tqct_pkg::DIV_W-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            crossing_time   <= job.fail ? tqct_pkg::FAIL_TIME : t_sat;
            crossing_status <= job.fail;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
      state == ST_DIV |-> job.den != '0)
    else $error("divide by zero reached the divider");
  a_fail_time: assert property (@(posedge clk) disable iff (rst)
      out_valid && crossing_status |-> crossing_time == tqct_pkg::FAIL_TIME)
    else $error("error result carries wrong time");

endmodule

`default_nettype wire

[src/tot_qualified_crossing_time.sv]
// ----------------------------------------------------------------------------
// tot_qualified_crossing_time
// Leading-edge discriminator with time-over-threshold qualification and
// linear interpolation of the crossing time (8 fraction bits).
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_ready    | sample_value, sample_time, end_of_trace
//  out      | out_valid / out_ready  | crossing_time, crossing_status
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  The scanner takes one sample per clock and stalls only while the job queue is full.
//  Each waveform takes the interpolator through queue pop, multiply, divider set-up,
//  the 59-bit bit-serial divider and the output load; an error result skips from the pop
//  to the output load. Short traces back up into the queue and then into in_ready.
//  Reset (rst, synchronous) clears the scan state, the queue, the output valid flag and
//  all configuration registers to zero. The cfg port is always ready; write only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tot_qualified_crossing_time (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [tqct_pkg::VAL_W-1:0]      sample_value,
  input  wire logic [tqct_pkg::TS_W-1:0]              sample_time,
  input  wire logic                                   end_of_trace,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [tqct_pkg::TIME_W-1:0]                 crossing_time,
  output logic                                        crossing_status,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [tqct_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tqct_pkg::TS_W-1:0]              cfg_data
);

  // Configuration registers
  logic signed [tqct_pkg::THR_W-1:0]  threshold;
  logic signed [tqct_pkg::VAL_W-1:0]  baseline_offset;
  logic [tqct_pkg::TS_W-1:0]          tot_window;

  // Scanner to interpolator queue
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  tqct_pkg::job_t push_job;
  tqct_pkg::job_t pop_job;

  assign cfg_ready = 1'b1;

  // Take a write; indexes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      baseline_offset <= '0;
      tot_window      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tqct_pkg::CFG_THRESHOLD: threshold       <= cfg_data[tqct_pkg::THR_W-1:0];
        tqct_pkg::CFG_BASELINE:  baseline_offset <= cfg_data[tqct_pkg::VAL_W-1:0];
        tqct_pkg::CFG_WINDOW:    tot_window      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: scan samples, qualify the candidate, hand a job over at the end mark
  tqct_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_value    (sample_value),
    .sample_time     (sample_time),
    .end_of_trace    (end_of_trace),
    .threshold       (threshold),
    .baseline_offset (baseline_offset),
    .tot_window      (tot_window),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  // Decouple the two sides so the slow divide holds the sample stream only while the queue is full
  tqct_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  // Back: interpolate the crossing time and hold the result for the sink
  tqct_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .crossing_time   (crossing_time),
    .crossing_status (crossing_status)
  );

endmodule

`default_nettype wire

[test/tb_tot_qualified_crossing_time.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tot_qualified_crossing_time
// Self-checking bench for the time-over-threshold crossing-time block. A short
// table of hand-picked waveforms is followed by random pulse trains under a
// range of threshold, baseline and window settings. An in-bench model of the
// scan and the interpolation predicts each result not typed into the table,
// and a monitor compares each result as it leaves the block.
// ----------------------------------------------------------------------------

module tb_tot_qualified_crossing_time;

  import tqct_pkg::*;

  // Bench timing
  localparam int     SETTLE_CYCLES = 150;    // covers two queued interpolations
  localparam int     ITEMS_PER_SET = 78;     // least samples per register setting
  localparam int     SETS_PER_PASS = 4;
  localparam longint TIME_CEILING  = (longint'(1) <<< TIME_W) - 1;

  // One crossing result as it leaves the block
  typedef struct packed {
    logic [TIME_W-1:0] ctime;
    logic              status;
  } crossing_t;

  // One row of the directed table; the result is typed in only where known
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [TS_W-1:0]         ts;
    logic                    eot;
    logic                    known;
    logic [TIME_W-1:0]       ctime;
    logic                    status;
  } sample_row_t;

  localparam int N_ROWS = 19;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] sample_value = '0;
  logic [TS_W-1:0]         sample_time = '0;
  logic                    end_of_trace = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TIME_W-1:0]       crossing_time;
  logic                    crossing_status;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_THRESHOLD;
  logic [TS_W-1:0]         cfg_data = '0;

  always #5 clk = ~clk;

  tot_qualified_crossing_time DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_value    (sample_value),
    .sample_time     (sample_time),
    .end_of_trace    (end_of_trace),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .crossing_time   (crossing_time),
    .crossing_status (crossing_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  crossing_t pending_crossings[$];  // predicted results, oldest first
  int        in_gap_pct  = 0;       // chance per cycle that the sender holds off
  int        out_gap_pct = 0;       // chance per cycle that the receiver stalls
  int        error_count = 0;
  int        samples_sent = 0;
  int        traces_sent = 0;
  int        results_checked = 0;
  int        settings_applied = 0;

  // Shadow copy of the configuration registers
  logic signed [THR_W-1:0] thr_reg;
  logic signed [VAL_W-1:0] base_reg;
  logic [TS_W-1:0]         win_reg;

  // Shadow copy of the per-waveform scan state
  logic                    trk_checking;
  logic                    trk_stopped;
  logic [IDX_W-1:0]        trk_index;
  logic signed [VAL_W-1:0] prev_val;
  logic [TS_W-1:0]         prev_ts;
  logic [IDX_W-1:0]        cand_idx;
  logic signed [VAL_W-1:0] cand_val;
  logic [TS_W-1:0]         cand_ts;
  logic signed [VAL_W-1:0] pre_val;
  logic [TS_W-1:0]         pre_ts;

  // Directed waveforms under the reset configuration (all registers zero)
  sample_row_t directed_rows [N_ROWS] = '{
    // lone sample above threshold: candidate sits at index 0
    '{16'sh7FFF, 32'h0000_0000, 1'b1, 1'b1, FAIL_TIME, 1'b1},
    // candidate is the last sample; the timestamp also runs backwards
    '{16'sh8000, 32'hFFFF_FFFF, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd100,  32'h0000_0005, 1'b1, 1'b1, FAIL_TIME, 1'b1},
    // never above: a value equal to the threshold does not count
    '{-16'sd5,   32'h0000_0000, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd0,    32'h0000_0001, 1'b1, 1'b1, FAIL_TIME, 1'b1},
    // clean leading edge, qualified by a later sample
    '{16'sd0,    32'h0000_0000, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd200,  32'h0000_000A, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd300,  32'h0000_0014, 1'b1, 1'b0, 40'd0, 1'b0},
    // timestamps at the top of the range
    '{16'sd0,    32'hFFFF_FFF0, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd1,    32'hFFFF_FFFF, 1'b1, 1'b0, 40'd0, 1'b0},
    // decreasing timestamps give a negative time difference
    '{16'sd0,    32'h0000_03E8, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd50,   32'h0000_0064, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd60,   32'h0000_0032, 1'b1, 1'b0, 40'd0, 1'b0},
    // first candidate drops inside the window, the second one qualifies
    '{16'sd0,    32'h0000_0000, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd10,   32'h0000_0001, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd0,    32'h0000_0001, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd20,   32'h0000_0005, 1'b0, 1'b0, 40'd0, 1'b0},
    '{16'sd30,   32'h0000_0009, 1'b1, 1'b0, 40'd0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Crossing-time predictor
  // --------------------------------------------------------------------------
  function automatic void clear_trace_state();
    trk_checking = 1'b0;
    trk_stopped  = 1'b0;
    trk_index    = '0;
    prev_val     = '0;
    prev_ts      = '0;
    cand_idx     = '0;
    cand_val     = '0;
    cand_ts      = '0;
    pre_val      = '0;
    pre_ts       = '0;
  endfunction

  // Advance the scan by one sample; returns 1 with the crossing at an end mark
  function automatic bit advance_trace(input logic signed [VAL_W-1:0] sv,
                                       input logic [TS_W-1:0] ts,
                                       input logic eot,
                                       output crossing_t res);
    bit     above;
    longint win_end;
    longint y1, y2, den, dt, num, q, t;

    res = '{FAIL_TIME, 1'b1};
    if (!trk_stopped) begin
      above = (int'(sv) - int'(base_reg)) > int'(thr_reg);
      if (!trk_checking && above) begin
        cand_idx     = trk_index;
        cand_val     = sv;
        cand_ts      = ts;
        pre_val      = prev_val;
        pre_ts       = prev_ts;
        trk_checking = 1'b1;
      end
      if (trk_checking) begin
        win_end = longint'(cand_ts) + longint'(win_reg);
        if (!(above && longint'(ts) <= win_end)) begin
          trk_checking = 1'b0;
          if (longint'(ts) > win_end) trk_stopped = 1'b1;
        end
      end
    end
    prev_val = sv;
    prev_ts  = ts;

    if (!eot) begin
      if (trk_index != IDX_LAST) trk_index = trk_index + 1'b1;
      return 1'b0;
    end

    // End mark: interpolate between the sample before the candidate and it
    y1  = longint'(cand_val) - longint'(base_reg);
    y2  = longint'(pre_val) - longint'(base_reg);
    den = y1 - y2;
    if (cand_idx != '0 && cand_idx != trk_index && den > 0) begin
      dt  = longint'(cand_ts) - longint'(pre_ts);
      num = (y1 - longint'(thr_reg)) * dt * (longint'(1) <<< FRAC_W);
      // round half away from zero
      if (num >= 0) q = (num + den / 2) / den;
      else          q = -((-num + den / 2) / den);
      t = (longint'(cand_ts) <<< FRAC_W) - q;
      if (t < 0) t = 0;
      if (t > TIME_CEILING) t = TIME_CEILING;
      res = '{t[TIME_W-1:0], 1'b0};
    end
    clear_trace_state();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sample channel driver
  // --------------------------------------------------------------------------
  // Offer one sample, hold it until accepted, then record the expected result.
  // Valid is left high on return so that back-to-back items need no toggle.
  task automatic send_sample(input logic signed [VAL_W-1:0] sv,
                             input logic [TS_W-1:0] ts,
                             input logic eot,
                             input bit known,
                             input crossing_t typed_res);
    crossing_t res;

    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= sv;
    sample_time  <= ts;
    end_of_trace <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    if (advance_trace(sv, ts, eot, res)) begin
      traces_sent++;
      // typed rows still run through the predictor to keep its state in step
      pending_crossings.push_back(known ? typed_res : res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration channel
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [TS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg  = data[THR_W-1:0];
      CFG_BASELINE:  base_reg = data[VAL_W-1:0];
      CFG_WINDOW:    win_reg  = data;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every outstanding result and let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int thr, input int base, input logic [TS_W-1:0] win);
    settle();
    write_register(CFG_THRESHOLD, TS_W'(thr));
    write_register(CFG_BASELINE,  TS_W'(base));
    write_register(CFG_WINDOW,    win);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Random waveforms
  // --------------------------------------------------------------------------
  // Map a baseline-corrected level back to a clipped digitiser code
  function automatic logic signed [VAL_W-1:0] to_code(input int corr);
    int v;
    v = corr + int'(base_reg);
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return VAL_W'(v);
  endfunction

  // One waveform: pulse trains around the threshold, or pure noise now and then
  task automatic send_random_trace();
    logic signed [VAL_W-1:0] vals[$];
    logic [TS_W-1:0]         ts;
    int                      thr, segs, lo, hi, n, step_cap;

    thr = int'(thr_reg);
    step_cap = (win_reg < 40) ? 2 * int'(win_reg) + 3 : 60;

    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) vals.push_back(VAL_W'($urandom));
    end else begin
      segs = $urandom_range(1, 3);
      repeat (segs) begin
        lo = $urandom_range(0, 4);
        repeat (lo) vals.push_back(to_code(thr - $urandom_range(0, 400)));
        hi = $urandom_range(1, 10);
        repeat (hi) begin
          // the odd dip below threshold breaks the time over threshold
          if ($urandom_range(9) == 0) vals.push_back(to_code(thr - $urandom_range(0, 400)));
          else                        vals.push_back(to_code(thr + $urandom_range(1, 400)));
        end
      end
      lo = $urandom_range(0, 3);
      repeat (lo) vals.push_back(to_code(thr - $urandom_range(0, 400)));
    end

    case ($urandom_range(7))
      0:       ts = $urandom;
      1:       ts = 32'hFFFF_FF00 + $urandom_range(0, 255);
      default: ts = $urandom_range(0, 100000);
    endcase

    foreach (vals[i]) begin
      if (i != 0) begin
        if ($urandom_range(24) == 0) ts = ts - $urandom_range(1, 30);
        else                         ts = ts + $urandom_range(0, step_cap);
      end
      send_sample(vals[i], ts, i == vals.size() - 1, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    crossing_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_crossings.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got time %h status %b",
                 $time, crossing_time, crossing_status);
        error_count++;
      end else begin
        want = pending_crossings.pop_front();
        results_checked++;
        if (crossing_time !== want.ctime) begin
          $display("%0t ns: crossing_time expected %h, got %h",
                   $time, want.ctime, crossing_time);
          error_count++;
        end
        if (crossing_status !== want.status) begin
          $display("%0t ns: crossing_status expected %b, got %b",
                   $time, want.status, crossing_status);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_gap_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int        base_items, thr, base, pick;
    logic [TS_W-1:0] win;
    crossing_t typed;

    thr_reg  = '0;
    base_reg = '0;
    win_reg  = '0;
    clear_trace_state();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset configuration
    foreach (directed_rows[i]) begin
      typed = '{directed_rows[i].ctime, directed_rows[i].status};
      send_sample(directed_rows[i].val, directed_rows[i].ts, directed_rows[i].eot,
                  directed_rows[i].known, typed);
    end

    // Random part in three passes: receiver slow, sender slow, then flat out
    for (int pass = 0; pass < 3; pass++) begin
      in_gap_pct  = (pass == 0) ? 32 : (pass == 1) ? 70 : 0;
      out_gap_pct = (pass == 0) ? 70 : (pass == 1) ? 32 : 0;
      for (int s = 0; s < SETS_PER_PASS; s++) begin
        if (pass == 0 && s == 0) begin
          // nothing can rise above: maximum threshold, minimum baseline
          thr = 65535; base = -32768; win = 32'hFFFF_FFFF;
        end else if (pass == 0 && s == 1) begin
          thr = -65535; base = 32767; win = '0;
        end else begin
          pick = $urandom_range(9);
          thr  = (pick == 0) ? 65535 : (pick == 1) ? -65535 : (pick == 2) ? 0 :
                 (pick == 3) ? int'($urandom_range(0, 131070)) - 65535 :
                               int'($urandom_range(0, 4000)) - 2000;
          pick = $urandom_range(9);
          base = (pick == 0) ? -32768 : (pick == 1) ? 32767 :
                 (pick < 5)  ? int'($urandom_range(0, 65535)) - 32768 :
                               int'($urandom_range(0, 2000)) - 1000;
          pick = $urandom_range(9);
          win  = (pick == 0) ? '0 : (pick == 1) ? 32'hFFFF_FFFF :
                 (pick == 2) ? TS_W'($urandom) : TS_W'($urandom_range(0, 40));
        end
        apply_setting(thr, base, win);
        base_items = samples_sent;
        while (samples_sent - base_items < ITEMS_PER_SET) send_random_trace();
      end
    end

    settle();
    $display("Sent %0d samples in %0d waveforms across %0d register settings;",
             samples_sent, traces_sent, settings_applied + 1);
    $display("checked %0d crossing results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still outstanding", pending_crossings.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
src/tqct_pkg.sv
src/tqct_queue.sv
src/tqct_front.sv
src/tqct_back.sv
src/tot_qualified_crossing_time.sv
test/tb_tot_qualified_crossing_time.sv
